FILE: rtl/sm4_pkg.sv
// sm4 package: pipeline beat type, s-box, transforms and round constants
`default_nettype none
package sm4_pkg;

  typedef struct packed {
    logic              vld;
    logic              dec;
    logic [3:0][31:0]  x;
    logic [3:0][31:0]  k;
  } sm4_beat_t;

  localparam logic [3:0][31:0] FK = {32'hB27022DC, 32'h677D9197, 32'h56AA3350, 32'hA3B1BAC6};

  localparam logic [7:0] SBOX [0:255] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] t_data(input logic [31:0] v);
    logic [31:0] b;
    b = tau(v);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] v);
    logic [31:0] b;
    b = tau(v);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic logic [31:0] ck_word(input int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'(((4 * i + j) * 7) & 8'hFF)};
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sm4_key_cell.sv
// sm4 key cell: one forward key-schedule step for decrypt beats, delay otherwise
`default_nettype none
module sm4_key_cell import sm4_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [31:0] ck,
  input  wire sm4_beat_t   d,
  output sm4_beat_t        q
);
  sm4_beat_t q_next;
  logic [31:0] knew;

  always_comb begin
    knew   = d.k[0] ^ t_key(d.k[1] ^ d.k[2] ^ d.k[3] ^ ck);
    q_next = d;
    if (d.dec) begin
      q_next.k = {knew, d.k[3], d.k[2], d.k[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sm4_round_cell.sv
// sm4 round cell: one data round with its round key, key window forward or backward
`default_nettype none
module sm4_round_cell import sm4_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [31:0] ck_fwd,
  input  wire logic [31:0] ck_bwd,
  input  wire sm4_beat_t   d,
  output sm4_beat_t        q
);
  sm4_beat_t q_next;
  logic [31:0] kfwd;
  logic [31:0] kbwd;
  logic [31:0] rk;
  logic [31:0] xnew;

  always_comb begin
    kfwd   = d.k[0] ^ t_key(d.k[1] ^ d.k[2] ^ d.k[3] ^ ck_fwd);
    kbwd   = d.k[3] ^ t_key(d.k[0] ^ d.k[1] ^ d.k[2] ^ ck_bwd);
    rk     = d.dec ? d.k[3] : kfwd;
    xnew   = d.x[0] ^ t_data(d.x[1] ^ d.x[2] ^ d.x[3] ^ rk);
    q_next = d;
    q_next.x = {xnew, d.x[3], d.x[2], d.x[1]};
    if (d.dec) begin
      q_next.k = {d.k[2], d.k[1], d.k[0], kbwd};
    end else begin
      q_next.k = {kfwd, d.k[3], d.k[2], d.k[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sm4_block_cipher.sv
// sm4 block cipher top: key-schedule cell row followed by round cell row
// throughput: one block per cycle while the output beat is not stalled; each cell does one key or round step
// the whole row advances together and holds while the output beat is stalled
// reset clears the valid bits of all cells; no clearing pass
`default_nettype none
module sm4_block_cipher import sm4_pkg::*; #(
  parameter int ROUNDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word0,
  input  wire logic [31:0] data_word1,
  input  wire logic [31:0] data_word2,
  input  wire logic [31:0] data_word3,
  input  wire logic [31:0] key_word0,
  input  wire logic [31:0] key_word1,
  input  wire logic [31:0] key_word2,
  input  wire logic [31:0] key_word3,
  input  wire logic        decrypt,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_word0,
  output logic [31:0]      result_word1,
  output logic [31:0]      result_word2,
  output logic [31:0]      result_word3
);
  sm4_beat_t st [0:2*ROUNDS];
  logic      adv;

  assign adv      = !st[2*ROUNDS].vld || out_ready;
  assign in_ready = adv;

  always_comb begin
    st[0].vld = in_valid;
    st[0].dec = decrypt;
    st[0].x   = {data_word3, data_word2, data_word1, data_word0};
    st[0].k   = {key_word3, key_word2, key_word1, key_word0} ^ FK;
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_key
    sm4_key_cell u_key (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .ck  (ck_word(i)),
      .d   (st[i]),
      .q   (st[i+1])
    );
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_rnd
    sm4_round_cell u_rnd (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .ck_fwd (ck_word(i)),
      .ck_bwd (ck_word(ROUNDS - 1 - i)),
      .d      (st[ROUNDS+i]),
      .q      (st[ROUNDS+i+1])
    );
  end

  assign out_valid    = st[2*ROUNDS].vld;
  assign result_word0 = st[2*ROUNDS].x[3];
  assign result_word1 = st[2*ROUNDS].x[2];
  assign result_word2 = st[2*ROUNDS].x[1];
  assign result_word3 = st[2*ROUNDS].x[0];
endmodule
`default_nettype wire

FILE: rtl/sm4_checker.sv
// sm4 port checker and its bind to the top level
`default_nettype none
module sm4_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result_word0
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("input beat withdrawn");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output beat dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result_word0)) else $error("output beat changed");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready) else $error("ready low without stall");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("valid after reset");
endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_word0 (result_word0)
);
`default_nettype wire

FILE: tb/tb_sm4_block_cipher.sv
// testbench for sm4_block_cipher: random and directed blocks checked against a cipher predictor
`timescale 1ns / 1ps
module tb_sm4_block_cipher;
  import sm4_pkg::SBOX;

  typedef struct {
    logic [31:0] w [4];
  } block_t;

  localparam logic [31:0] FK_WORDS [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};
  localparam int STALL_LIMIT = 5000;

  function automatic logic [31:0] sub_bytes(logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rol(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic block_t sm4_cipher(block_t blk, block_t key, bit dec);
    logic [31:0] k [36];
    logic [31:0] rk [32];
    logic [31:0] x [36];
    logic [31:0] b, c, r;
    block_t res;
    for (int i = 0; i < 4; i++) begin
      k[i] = key.w[i] ^ FK_WORDS[i];
      x[i] = blk.w[i];
    end
    for (int i = 0; i < 32; i++) begin
      c = '0;
      for (int j = 0; j < 4; j++) c = {c[23:0], 8'(((4 * i + j) * 7) & 255)};
      b = sub_bytes(k[i+1] ^ k[i+2] ^ k[i+3] ^ c);
      k[i+4] = k[i] ^ b ^ rol(b, 13) ^ rol(b, 23);
      rk[i] = k[i+4];
    end
    for (int i = 0; i < 32; i++) begin
      r = dec ? rk[31-i] : rk[i];
      b = sub_bytes(x[i+1] ^ x[i+2] ^ x[i+3] ^ r);
      x[i+4] = x[i] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
    end
    for (int i = 0; i < 4; i++) res.w[i] = x[35-i];
    return res;
  endfunction

  class cipher_scoreboard;
    block_t pending[$];
    int mismatches = 0;

    function void note_block(block_t blk, block_t key, bit dec);
      pending.push_back(sm4_cipher(blk, key, dec));
    endfunction

    function void check_result(block_t got);
      block_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h %h %h %h",
          got.w[0], got.w[1], got.w[2], got.w[3]);
        return;
      end
      exp = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (got.w[i] !== exp.w[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result_word%0d mismatch: expected %h got %h", i, exp.w[i], got.w[i]);
        end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, decrypt = 0;
  logic [31:0] data_word0 = 0, data_word1 = 0, data_word2 = 0, data_word3 = 0;
  logic [31:0] key_word0 = 0, key_word1 = 0, key_word2 = 0, key_word3 = 0;
  logic in_ready, out_valid;
  logic [31:0] result_word0, result_word1, result_word2, result_word3;

  cipher_scoreboard sb = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  sm4_block_cipher dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    block_t blk, key, got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        blk.w = '{data_word0, data_word1, data_word2, data_word3};
        key.w = '{key_word0, key_word1, key_word2, key_word3};
        sb.note_block(blk, key, decrypt);
      end
      if (out_valid && out_ready) begin
        got.w = '{result_word0, result_word1, result_word2, result_word3};
        sb.check_result(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_block(block_t blk, block_t key, bit dec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    {data_word0, data_word1, data_word2, data_word3} <= {blk.w[0], blk.w[1], blk.w[2], blk.w[3]};
    {key_word0, key_word1, key_word2, key_word3} <= {key.w[0], key.w[1], key.w[2], key.w[3]};
    decrypt <= dec;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic block_t rand_block(int kind);
    block_t b;
    for (int i = 0; i < 4; i++)
      case (kind)
        0: b.w[i] = '0;
        1: b.w[i] = '1;
        default: b.w[i] = $urandom();
      endcase
    return b;
  endfunction

  task automatic send_random(int n);
    block_t b, k;
    repeat (n) begin
      b = rand_block($urandom_range(2, 20) > 2 ? 2 : $urandom_range(0, 1));
      k = rand_block($urandom_range(2, 20) > 2 ? 2 : $urandom_range(0, 1));
      send_block(b, k, $urandom_range(1));
    end
  endtask

  initial begin
    block_t b, k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // standard test vector and its inverse
    b.w = '{32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210};
    send_block(b, b, 0);
    b.w = '{32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246};
    k.w = '{32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210};
    send_block(b, k, 1);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int d = 0; d < 2; d++) send_block(rand_block(i), rand_block(j), d);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 65 : 34) : 0;
      send_random(100);
      if (ph == 0) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
          send_random(100);
        join
      end
      send_random(100);
    end
    in_valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        $display("Regression FAIL");
        $finish;
      end
    join_any
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: sim.f
rtl/sm4_pkg.sv
rtl/sm4_key_cell.sv
rtl/sm4_round_cell.sv
rtl/sm4_block_cipher.sv
rtl/sm4_checker.sv
tb/tb_sm4_block_cipher.sv
